### sv/kvt_pkg.sv
// shared types and codes for the key/value table
`default_nettype none
package kvt_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] key;
        logic [31:0]        value;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_out;
        logic [4:0]  entry_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### sv/kvt_slot_ram.sv
// simple dual-port slot memory with registered read data
`default_nettype none
module kvt_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire logic [WIDTH-1:0]           i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]                o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule
`default_nettype wire

### sv/key_value_table.sv
// sequence: after the start transfer the slot scan reads every slot, then S_DRAIN and S_DONE follow;
//   the result and its strobe are registered from S_DONE, and a new request is taken only back in S_IDLE;
//   the slot scan reads one slot per cycle from the key memory
// reset: a clearing pass over every slot marks each one free; busy stays high
// the result strobe lasts one cycle and the receiver cannot stall it
`default_nettype none
module key_value_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire kvt_pkg::t_req i_req,
    output logic               o_strobe,
    output kvt_pkg::t_rsp      o_rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    kvt_pkg::t_state r_state, n_state;
    kvt_pkg::t_req   r_req;
    kvt_pkg::t_rsp   r_rsp, n_rsp;
    logic            r_strobe;

    logic [IDX_W-1:0] r_addr;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [31:0]      r_hit_val;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;
    logic [CNT_W-1:0] r_count, n_count;

    // key word: valid flag on top of the key bits
    logic             key_wr_en;
    logic [IDX_W-1:0] key_wr_addr;
    logic [32:0]      key_wr_data;
    logic [32:0]      key_rd_data;
    logic             val_wr_en;
    logic [IDX_W-1:0] val_wr_addr;
    logic [31:0]      val_rd_data;

    logic             match;
    logic             empty;
    logic [CNT_W+4:0] count_ext;

    kvt_slot_ram #(.DEPTH(ENTRIES), .WIDTH(33)) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_wr_en),
        .i_wr_addr (key_wr_addr),
        .i_wr_data (key_wr_data),
        .i_rd_addr (r_addr),
        .o_rd_data (key_rd_data)
    );

    kvt_slot_ram #(.DEPTH(ENTRIES), .WIDTH(32)) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (val_wr_en),
        .i_wr_addr (val_wr_addr),
        .i_wr_data (r_req.value),
        .i_rd_addr (r_addr),
        .o_rd_data (val_rd_data)
    );

    assign match = r_rd_vld && key_rd_data[32] && (key_rd_data[31:0] == r_req.key);
    assign empty = r_rd_vld && !key_rd_data[32];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kvt_pkg::S_CLEAR: begin
                if (r_addr == LAST_IDX) n_state = kvt_pkg::S_IDLE;
            end
            kvt_pkg::S_IDLE: begin
                if (start) n_state = kvt_pkg::S_SCAN;
            end
            kvt_pkg::S_SCAN: begin
                if (r_addr == LAST_IDX) n_state = kvt_pkg::S_DRAIN;
            end
            kvt_pkg::S_DRAIN: n_state = kvt_pkg::S_DONE;
            kvt_pkg::S_DONE:  n_state = kvt_pkg::S_IDLE;
            default:          n_state = kvt_pkg::S_IDLE;
        endcase
    end

    // outputs and memory writes
    always_comb begin
        busy        = (r_state != kvt_pkg::S_IDLE);
        key_wr_en   = 1'b0;
        key_wr_addr = r_addr;
        key_wr_data = {1'b0, r_req.key};
        val_wr_en   = 1'b0;
        val_wr_addr = r_hit_idx;
        n_count     = r_count;
        n_rsp       = r_rsp;
        unique case (r_state)
            kvt_pkg::S_CLEAR: begin
                key_wr_en   = 1'b1;
                key_wr_data = '0;
            end
            kvt_pkg::S_DONE: begin
                n_rsp.status    = kvt_pkg::ST_NOT_FOUND;
                n_rsp.value_out = '0;
                unique case (r_req.func)
                    kvt_pkg::FUNC_INSERT: begin
                        if (r_hit) begin
                            val_wr_en    = 1'b1;
                            n_rsp.status = kvt_pkg::ST_UPDATED;
                        end else if (r_free) begin
                            key_wr_en    = 1'b1;
                            key_wr_addr  = r_free_idx;
                            key_wr_data  = {1'b1, r_req.key};
                            val_wr_en    = 1'b1;
                            val_wr_addr  = r_free_idx;
                            n_count      = r_count + 1'b1;
                            n_rsp.status = kvt_pkg::ST_INSERTED;
                        end else begin
                            n_rsp.status = kvt_pkg::ST_FULL;
                        end
                    end
                    kvt_pkg::FUNC_LOOKUP: begin
                        if (r_hit) begin
                            n_rsp.status    = kvt_pkg::ST_FOUND;
                            n_rsp.value_out = r_hit_val;
                        end
                    end
                    kvt_pkg::FUNC_REMOVE: begin
                        if (r_hit) begin
                            key_wr_en    = 1'b1;
                            key_wr_addr  = r_hit_idx;
                            key_wr_data  = {1'b0, r_req.key};
                            n_count      = r_count - 1'b1;
                            n_rsp.status = kvt_pkg::ST_REMOVED;
                        end
                    end
                    default: ;
                endcase
                count_ext         = {5'b0, n_count};
                n_rsp.entry_count = count_ext[4:0];
            end
            default: ;
        endcase
        count_ext = {5'b0, n_count};
        if (r_state == kvt_pkg::S_DONE) begin
            n_rsp.entry_count = count_ext[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kvt_pkg::S_CLEAR;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
            r_count  <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == kvt_pkg::S_SCAN);
            r_strobe <= (r_state == kvt_pkg::S_DONE);
            r_count  <= n_count;
            if (r_state == kvt_pkg::S_CLEAR || r_state == kvt_pkg::S_SCAN) begin
                r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
            end
            if (r_state == kvt_pkg::S_IDLE && start) begin
                r_addr <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else begin
                if (match) r_hit <= 1'b1;
                // lowest free slot wins
                if (empty && !r_free) r_free <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        r_rsp    <= n_rsp;
        if (r_state == kvt_pkg::S_IDLE && start) begin
            r_req <= i_req;
        end
        if (match) begin
            r_hit_idx <= r_rd_idx;
            r_hit_val <= val_rd_data;
        end
        if (empty && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
`default_nettype wire
